// ----- hw/rtl/lspc_pkg.sv -----
// shared constants, codes and structs for the lifo stack with palindrome check
// no dependencies

package lspc_pkg;

    localparam int STACK_DEPTH = 8;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_W     = 4;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_CHECK = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } mem_req_t;

    typedef struct packed {
        status_t            status;
        logic [DATA_W-1:0]  popped;
        logic               flag;
        logic [DEPTH_W-1:0] depth;
    } result_t;

endpackage

// ----- hw/rtl/lifo_stack_with_palindrome_check.sv -----
// channel  dir  tdata (low bit up)                        tuser
// s_       in   push_value[31:0]                          command[1:0]
// m_       out  popped_value[31:0] palindrome_flag depth  status[1:0]
//
// push, unused command and any error case go straight to the result; pop first passes through a ram read state
// check of n entries: one mirrored pair read per cycle from the two ram copies
// reset clears the entry count and control; ram contents stay undefined, no clearing pass
// a finished result waits in the sequencer while the output register is still held
// top level: sequencer, two mirrored rams, output register; depends on lspc_pkg, lspc_ram, lspc_seq

module lifo_stack_with_palindrome_check
    import lspc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // push_value
    input  logic [CMD_W-1:0]     s_tuser,   // command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // popped_value, palindrome_flag, depth_now, zero pad
    output logic [STATUS_W-1:0]  m_tuser    // status
);

    mem_req_t             mem_req;
    result_t              result;
    logic [DATA_W-1:0]    rdata_a;
    logic [DATA_W-1:0]    rdata_b;
    logic                 done;
    logic                 out_free;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0]  m_tuser_reg;

    lspc_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (s_tvalid),
        .cmd_ready  (s_tready),
        .cmd        (s_tuser),
        .push_value (s_tdata[DATA_W-1:0]),
        .mem_req    (mem_req),
        .rdata_a    (rdata_a),
        .rdata_b    (rdata_b),
        .out_free   (out_free),
        .done       (done),
        .result     (result)
    );

    lspc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr_a),
        .rdata (rdata_a)
    );

    lspc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr_b),
        .rdata (rdata_b)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_tvalid_reg <= done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && out_free)
        begin
            m_tdata_reg <= M_TDATA_W'({result.depth, result.flag, result.popped});
            m_tuser_reg <= result.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (s_tvalid && s_tready))
        else $error("ram write outside a command transfer");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second command taken while one is in flight");

    a_clean_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata[DATA_W:0] == '0))
        else $error("value or flag set on an error result");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_OVERFLOW))
            |-> (m_tdata[DATA_W+DEPTH_W:DATA_W+1] == DEPTH_W'(STACK_DEPTH)))
        else $error("overflow reported below full depth");
`endif

endmodule

// ----- hw/rtl/lspc_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies

module lspc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/lspc_seq.sv -----
// command sequencer: entry count, ram read/write requests, mirrored pair walk
// depends on lspc_pkg

module lspc_seq
    import lspc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [DATA_W-1:0] push_value,
    output mem_req_t          mem_req,
    input  logic [DATA_W-1:0] rdata_a,
    input  logic [DATA_W-1:0] rdata_b,
    input  logic              out_free,
    output logic              done,
    output result_t           result
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_POP  = 4'b0010,
        S_CHK  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] lo_reg, lo_next;
    logic [ADDR_W-1:0] hi_reg, hi_next;
    logic              match_reg, match_next;
    status_t           status_reg, status_next;
    logic [DATA_W-1:0] popped_reg, popped_next;
    logic              flag_reg, flag_next;
    logic [CNT_W-1:0]  cnt_dec;
    logic              accept;
    logic              pair_eq;

    assign cmd_ready = (state_reg == S_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign cnt_dec   = count_reg - CNT_W'(1);
    assign pair_eq   = (rdata_a == rdata_b);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        match_next  = match_reg;
        status_next = status_reg;
        popped_next = popped_reg;
        flag_next   = flag_reg;
        mem_req     = '0;
        mem_req.waddr   = count_reg[ADDR_W-1:0];
        mem_req.wdata   = push_value;
        mem_req.raddr_a = cnt_dec[ADDR_W-1:0];
        mem_req.raddr_b = cnt_dec[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    popped_next = '0;
                    flag_next   = 1'b0;
                    state_next  = S_DONE;
                    case (cmd_t'(cmd))
                        CMD_PUSH:
                        begin
                            if (count_reg == CNT_W'(STACK_DEPTH))
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                mem_req.we = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                count_next = cnt_dec;
                                state_next = S_POP;
                            end
                        end
                        CMD_CHECK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (count_reg == CNT_W'(1))
                            begin
                                flag_next = 1'b1;
                            end
                            else
                            begin
                                mem_req.raddr_a = '0;
                                lo_next         = ADDR_W'(1);
                                hi_next         = cnt_dec[ADDR_W-1:0] - ADDR_W'(1);
                                match_next      = 1'b1;
                                state_next      = S_CHK;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                popped_next = rdata_a;
                state_next  = S_DONE;
            end
            S_CHK:
            begin
                mem_req.raddr_a = lo_reg;
                mem_req.raddr_b = hi_reg;
                match_next      = match_reg && pair_eq;
                if (lo_reg < hi_reg)
                begin
                    lo_next = lo_reg + ADDR_W'(1);
                    hi_next = hi_reg - ADDR_W'(1);
                end
                else
                begin
                    flag_next  = match_reg && pair_eq;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        match_reg  <= match_next;
        status_reg <= status_next;
        popped_reg <= popped_next;
        flag_reg   <= flag_next;
    end

    assign done          = (state_reg == S_DONE);
    assign result.status = status_reg;
    assign result.popped = popped_reg;
    assign result.flag   = flag_reg;
    assign result.depth  = DEPTH_W'(count_reg);

endmodule

// ----- tb/sv/lspc_stack_checker.sv -----
// checker for the lifo stack with palindrome check: watches both stream channels,
// keeps its own stack and count, predicts every result and compares it field by field
// depends on lspc_pkg

module lspc_stack_checker
    import lspc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [CMD_W-1:0]     s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [STATUS_W-1:0]  m_tuser,
    output int                   mismatches,
    output int                   outstanding
);

    localparam int PAD_LO = DATA_W + 1 + DEPTH_W;

    logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
    int unsigned       shadow_fill;
    result_t           expected_q [$];

    function automatic result_t stack_apply(input logic [CMD_W-1:0] cmd,
                                            input logic [DATA_W-1:0] value);
        result_t r;
        r.status = ST_OK;
        r.popped = '0;
        r.flag   = 1'b0;
        case (cmd)
            CMD_PUSH:
            begin
                if (shadow_fill >= STACK_DEPTH)
                    r.status = ST_OVERFLOW;
                else
                begin
                    shadow_stack[shadow_fill] = value;
                    shadow_fill++;
                end
            end
            CMD_POP:
            begin
                if (shadow_fill == 0)
                    r.status = ST_UNDERFLOW;
                else
                begin
                    shadow_fill--;
                    r.popped = shadow_stack[shadow_fill];
                end
            end
            CMD_CHECK:
            begin
                if (shadow_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    // mirrored pairs, bottom against top
                    r.flag = 1'b1;
                    for (int i = 0; i < shadow_fill / 2; i++)
                        if (shadow_stack[i] != shadow_stack[shadow_fill - 1 - i])
                            r.flag = 1'b0;
                end
            end
            default: ;
        endcase
        r.depth = DEPTH_W'(shadow_fill);
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        result_t want;
        if (rst_n)
        begin
            // result side first: a result never belongs to a command taken on the same edge
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result transfer: tdata %h tuser %0d", m_tdata, m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        mismatches++;
                    end
                    if (m_tdata[DATA_W-1:0] !== want.popped)
                    begin
                        $error("popped_value: expected %0d, actual %0d",
                               $signed(want.popped), $signed(m_tdata[DATA_W-1:0]));
                        mismatches++;
                    end
                    if (m_tdata[DATA_W] !== want.flag)
                    begin
                        $error("palindrome_flag: expected %0d, actual %0d",
                               want.flag, m_tdata[DATA_W]);
                        mismatches++;
                    end
                    if (m_tdata[DATA_W+1 +: DEPTH_W] !== want.depth)
                    begin
                        $error("depth_now: expected %0d, actual %0d",
                               want.depth, m_tdata[DATA_W+1 +: DEPTH_W]);
                        mismatches++;
                    end
                    if (m_tdata[M_TDATA_W-1:PAD_LO] !== '0)
                    begin
                        $error("tdata padding: expected 0, actual %0d",
                               m_tdata[M_TDATA_W-1:PAD_LO]);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(stack_apply(s_tuser, s_tdata));
            outstanding <= expected_q.size();
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
// top of the stack testbench: clock, reset, command stimulus and result backpressure
// depends on lspc_pkg, lifo_stack_with_palindrome_check and lspc_stack_checker

module tb;
    import lspc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 1550;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [CMD_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    int                   mismatches;
    int                   outstanding;

    int fill;
    int sent;
    bit send_burst;
    bit ready_burst;

    lifo_stack_with_palindrome_check DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lspc_stack_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

    // one command transfer, then this item's gap
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (cmd == CMD_PUSH && fill < STACK_DEPTH)
            fill++;
        else if (cmd == CMD_POP && fill > 0)
            fill--;
        sent++;
        gap = send_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off until every result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // result side backpressure
    initial
    begin
        int stall;
        int taken;
        m_tready = 1'b0;
        taken = 0;
        ready_burst = 1'b0;
        wait (rst_n);
        forever
        begin
            stall = ready_burst ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            taken++;
            if (taken % 40 == 0)
                ready_burst = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        logic [DATA_W-1:0] pattern [STACK_DEPTH];
        logic [DATA_W-1:0] v;
        int n;
        int spoil;
        int pick;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = CMD_PUSH;
        fill       = 0;
        sent       = 0;
        send_burst = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cases, extremes, one entry, full stack, spare code
        send_cmd(CMD_CHECK, 32'hFFFF_FFFF);
        send_cmd(CMD_POP, 32'h5A5A_A5A5);
        send_cmd(CMD_PUSH, 32'h7FFF_FFFF);
        send_cmd(CMD_CHECK, 32'h0);
        send_cmd(CMD_PUSH, 32'h8000_0000);
        send_cmd(CMD_CHECK, 32'h0);
        send_cmd(CMD_POP, 32'h0);
        send_cmd(CMD_PUSH, 32'hFFFF_FFFF);
        send_cmd(CMD_PUSH, 32'h0);
        send_cmd(CMD_PUSH, 32'h0);
        send_cmd(CMD_PUSH, 32'hFFFF_FFFF);
        send_cmd(CMD_PUSH, 32'h7FFF_FFFF);
        send_cmd(CMD_CHECK, 32'hA5A5_5A5A);
        send_cmd(CMD_SPARE, 32'hFFFF_FFFF);
        send_cmd(CMD_PUSH, 32'h5);
        send_cmd(CMD_PUSH, 32'h5);
        send_cmd(CMD_PUSH, 32'h8000_0000);
        send_cmd(CMD_CHECK, 32'h0);
        send_cmd(CMD_SPARE, 32'h0);
        send_cmd(CMD_POP, 32'hFFFF_FFFF);
        send_cmd(CMD_CHECK, 32'h0);
        drain_results();

        while (sent < RANDOM_ITEMS + 21)
        begin
            send_burst = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 6)
            begin
                // well-formed: empty the stack, build a mirrored run, check it
                while (fill > 0)
                    send_cmd(CMD_POP, $urandom);
                n = $urandom_range(1, STACK_DEPTH);
                for (int i = 0; i < (n + 1) / 2; i++)
                begin
                    pick = $urandom_range(0, 3);
                    case (pick)
                        0: v = $urandom;
                        1: v = $urandom_range(0, 3);
                        2: v = {DATA_W{1'($urandom_range(0, 1))}};
                        default: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    endcase
                    pattern[i]         = v;
                    pattern[n - 1 - i] = v;
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    spoil          = $urandom_range(0, n - 1);
                    pattern[spoil] = pattern[spoil] ^ (32'd1 << $urandom_range(0, 31));
                end
                for (int i = 0; i < n; i++)
                    send_cmd(CMD_PUSH, pattern[i]);
                send_cmd(CMD_CHECK, $urandom);
                if ($urandom_range(0, 3) == 0)
                begin
                    repeat (STACK_DEPTH - n + 1) send_cmd(CMD_PUSH, $urandom);
                    send_cmd(CMD_CHECK, $urandom);
                end
                repeat ($urandom_range(0, n)) send_cmd(CMD_POP, $urandom);
                send_cmd(CMD_CHECK, $urandom);
            end
            else
            begin
                // noise: loose mix of every command
                repeat ($urandom_range(1, 12))
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4)
                        send_cmd(CMD_PUSH, $urandom);
                    else if (pick < 7)
                        send_cmd(CMD_POP, $urandom);
                    else if (pick < 9)
                        send_cmd(CMD_CHECK, $urandom);
                    else
                        send_cmd(CMD_SPARE, $urandom);
                end
            end
            if ($urandom_range(0, 19) == 0)
                drain_results();
        end

        drain_results();
        repeat (20) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/lspc_pkg.sv
hw/rtl/lspc_ram.sv
hw/rtl/lspc_seq.sv
hw/rtl/lifo_stack_with_palindrome_check.sv
tb/sv/lspc_stack_checker.sv
tb/sv/tb.sv
